/* sv/rrqs_pkg.sv */
`timescale 1ns / 1ps

package rrqs_pkg;

    localparam int REQ_TYPE_W = 1;
    localparam int JOB_ID_W   = 8;
    localparam int DUR_W      = 16;
    localparam int CPU_W      = 4;
    localparam int QUANTUM_W  = 8;
    localparam int TICK_W     = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd2;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_ARRIVAL = 1'b0,
        REQ_TICK    = 1'b1
    } t_req_type;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CPU_NUMBER   = 1'b0,
        CFG_TIME_QUANTUM = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [JOB_ID_W-1:0] id;
        logic [DUR_W-1:0]    remaining;
    } t_entry;

endpackage

/* sv/round_robin_quantum_scheduler.sv */
`timescale 1ns / 1ps

// channel   handshake                      payload
// -------   ----------------------------   ---------------------------------------------
// input     i_in_valid / o_in_ready        i_req_type i_job_id i_duration i_affinity
// output    o_out_valid / i_out_ready      o_accepted o_running_valid o_running_job
//                                          o_job_finished o_finish_time o_all_idle
// config    i_cfg_wr_en (no handshake)     i_cfg_addr i_cfg_wr_data
//
// One beat per cycle while o_in_ready is high; its result is registered on acceptance.
// The ready queue keeps its head entry in a register, reloaded from the queue memory
// each cycle with bypass of a same-cycle write, so a pop never waits on a memory read.
// Reset is synchronous; it clears the control state, queue memory is left as is.
// o_in_ready is low only while the output register holds a beat that is not taken.

module round_robin_quantum_scheduler #(
    parameter int QUEUE_DEPTH = rrqs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_cfg_wr_en,
    input  logic [rrqs_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [rrqs_pkg::CFG_DATA_W-1:0] i_cfg_wr_data,

    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [rrqs_pkg::REQ_TYPE_W-1:0] i_req_type,
    input  logic [rrqs_pkg::JOB_ID_W-1:0]   i_job_id,
    input  logic [rrqs_pkg::DUR_W-1:0]      i_duration,
    input  logic [rrqs_pkg::CPU_W-1:0]      i_affinity,

    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_accepted,
    output logic                            o_running_valid,
    output logic [rrqs_pkg::JOB_ID_W-1:0]   o_running_job,
    output logic                            o_job_finished,
    output logic [rrqs_pkg::TICK_W-1:0]     o_finish_time,
    output logic                            o_all_idle
);
    import rrqs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // configuration
    logic [CPU_W-1:0]     r_cpu_number;
    logic [QUANTUM_W-1:0] r_time_quantum;

    // queue
    t_entry               r_mem [QUEUE_DEPTH];
    t_entry               r_head_data;
    logic [PTR_W-1:0]     r_head, n_head;
    logic [PTR_W-1:0]     r_tail, n_tail;
    logic [CNT_W-1:0]     r_count, n_count;

    // running job
    logic                 r_cur_valid, n_cur_valid;
    logic [JOB_ID_W-1:0]  r_cur_id, n_cur_id;
    logic [DUR_W-1:0]     r_cur_rem, n_cur_rem;
    logic [QUANTUM_W-1:0] r_q_left, n_q_left;
    logic [TICK_W-1:0]    r_tick, n_tick;

    // result register
    logic                 r_out_valid;
    logic                 r_accepted, n_accepted;
    logic                 r_run_valid, n_run_valid;
    logic [JOB_ID_W-1:0]  r_run_job, n_run_job;
    logic                 r_finished, n_finished;
    logic [TICK_W-1:0]    r_ftime, n_ftime;
    logic                 r_all_idle, n_all_idle;

    logic                 accept;
    logic                 push;
    t_entry               push_data;

    logic                 pop;
    logic                 run0;
    logic [JOB_ID_W-1:0]  id0;
    logic [DUR_W-1:0]     rem0, rem1;
    logic [QUANTUM_W-1:0] q0, q1;
    logic [CNT_W-1:0]     cnt1;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_cur_valid = r_cur_valid;
        n_cur_id    = r_cur_id;
        n_cur_rem   = r_cur_rem;
        n_q_left    = r_q_left;
        n_tick      = r_tick;
        n_accepted  = 1'b0;
        n_run_valid = 1'b0;
        n_run_job   = '0;
        n_finished  = 1'b0;
        n_ftime     = '0;
        push        = 1'b0;
        push_data   = '{id: i_job_id, remaining: i_duration};

        pop  = !r_cur_valid && (r_count != '0);
        run0 = r_cur_valid || pop;
        id0  = pop ? r_head_data.id        : r_cur_id;
        rem0 = pop ? r_head_data.remaining : r_cur_rem;
        q0   = pop ? r_time_quantum        : r_q_left;
        cnt1 = r_count - CNT_W'(pop);
        rem1 = rem0 - 1'b1;
        q1   = q0 - 1'b1;

        if (accept) begin
            if (t_req_type'(i_req_type) == REQ_ARRIVAL) begin
                if (i_affinity == r_cpu_number && i_duration != '0 && r_count < CNT_FULL) begin
                    push       = 1'b1;
                    n_accepted = 1'b1;
                    n_count    = r_count + 1'b1;
                end
            end else begin
                n_count = cnt1;
                if (pop) begin
                    n_head = next_ptr(r_head);
                end
                if (run0) begin
                    n_run_valid = 1'b1;
                    n_run_job   = id0;
                    n_cur_id    = id0;
                    n_cur_rem   = rem1;
                    n_cur_valid = 1'b1;
                    n_q_left    = q1;
                    if (rem1 == '0) begin
                        n_finished  = 1'b1;
                        n_ftime     = r_tick;
                        n_cur_valid = 1'b0;
                        n_q_left    = '0;
                    end else if (q1 == '0) begin
                        if (cnt1 < CNT_FULL) begin
                            push        = 1'b1;
                            push_data   = '{id: id0, remaining: rem1};
                            n_count     = cnt1 + 1'b1;
                            n_cur_valid = 1'b0;
                        end else begin
                            n_q_left = r_time_quantum;
                        end
                    end
                end
                n_tick = r_tick + 1'b1;
            end
            if (push) begin
                n_tail = next_ptr(r_tail);
            end
        end
        n_all_idle = !n_cur_valid && (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_tail] <= push_data;
        end
        if (push && r_tail == n_head) begin
            r_head_data <= push_data;
        end else begin
            r_head_data <= r_mem[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_number   <= '0;
            r_time_quantum <= QUANTUM_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_CPU_NUMBER:   r_cpu_number   <= i_cfg_wr_data[CPU_W-1:0];
                CFG_TIME_QUANTUM: r_time_quantum <= i_cfg_wr_data[QUANTUM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_cur_valid <= 1'b0;
            r_cur_id    <= '0;
            r_cur_rem   <= '0;
            r_q_left    <= '0;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_cur_valid <= n_cur_valid;
            r_cur_id    <= n_cur_id;
            r_cur_rem   <= n_cur_rem;
            r_q_left    <= n_q_left;
            r_tick      <= n_tick;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_accepted  <= n_accepted;
            r_run_valid <= n_run_valid;
            r_run_job   <= n_run_job;
            r_finished  <= n_finished;
            r_ftime     <= n_ftime;
            r_all_idle  <= n_all_idle;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_accepted;
    assign o_running_valid = r_run_valid;
    assign o_running_job   = r_run_job;
    assign o_job_finished  = r_finished;
    assign o_finish_time   = r_ftime;
    assign o_all_idle      = r_all_idle;

endmodule

/* tb/tb_round_robin_quantum_scheduler.sv */
`timescale 1ns / 1ps

module tb_round_robin_quantum_scheduler;
    import rrqs_pkg::*;

    typedef struct packed {
        logic                accepted;
        logic                running_valid;
        logic [JOB_ID_W-1:0] running_job;
        logic                job_finished;
        logic [TICK_W-1:0]   finish_time;
        logic                all_idle;
    } t_sched_result;

    class rr_sched_tracker;
        logic [CPU_W-1:0]     cpu_id;
        logic [QUANTUM_W-1:0] quantum;
        t_entry               ready_q[$];
        logic                 busy;
        logic [JOB_ID_W-1:0]  cur_id;
        logic [DUR_W-1:0]     cur_left;
        logic [QUANTUM_W-1:0] slice_left;
        logic [TICK_W-1:0]    ticks;
        t_sched_result        pending_results[$];
        int unsigned          fail_count;

        function new();
            cpu_id     = '0;
            quantum    = QUANTUM_RESET;
            busy       = 1'b0;
            cur_id     = '0;
            cur_left   = '0;
            slice_left = '0;
            ticks      = '0;
            fail_count = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_CPU_NUMBER:   cpu_id  = val[CPU_W-1:0];
                CFG_TIME_QUANTUM: quantum = val[QUANTUM_W-1:0];
                default: ;
            endcase
        endfunction

        function bit idle();
            return !busy && ready_q.size() == 0;
        endfunction

        function void apply_request(t_req_type rt, logic [JOB_ID_W-1:0] id,
                                    logic [DUR_W-1:0] dur, logic [CPU_W-1:0] aff);
            t_sched_result r;
            t_entry        e;
            r = '0;
            if (rt == REQ_ARRIVAL) begin
                if (aff == cpu_id && dur != 0 && ready_q.size() < QUEUE_DEPTH_DEF) begin
                    e.id        = id;
                    e.remaining = dur;
                    ready_q.push_back(e);
                    r.accepted = 1'b1;
                end
            end else begin
                if (!busy && ready_q.size() > 0) begin
                    e          = ready_q.pop_front();
                    cur_id     = e.id;
                    cur_left   = e.remaining;
                    busy       = 1'b1;
                    slice_left = quantum;
                end
                if (busy) begin
                    r.running_valid = 1'b1;
                    r.running_job   = cur_id;
                    cur_left        = cur_left - 1'b1;
                    slice_left      = slice_left - 1'b1;
                    if (cur_left == 0) begin
                        r.job_finished = 1'b1;
                        r.finish_time  = ticks;
                        busy           = 1'b0;
                        slice_left     = '0;
                    end else if (slice_left == 0) begin
                        // requeue at tail; with a full queue the job keeps the CPU
                        if (ready_q.size() < QUEUE_DEPTH_DEF) begin
                            e.id        = cur_id;
                            e.remaining = cur_left;
                            ready_q.push_back(e);
                            busy = 1'b0;
                        end else begin
                            slice_left = quantum;
                        end
                    end
                end
                ticks = ticks + 1'b1;
            end
            r.all_idle = idle();
            pending_results.push_back(r);
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fail_count++;
            end
        endfunction

        function void compare_result(t_sched_result got);
            t_sched_result want;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            check_field("accepted", 16'(want.accepted), 16'(got.accepted));
            check_field("running_valid", 16'(want.running_valid), 16'(got.running_valid));
            check_field("running_job", 16'(want.running_job), 16'(got.running_job));
            check_field("job_finished", 16'(want.job_finished), 16'(got.job_finished));
            check_field("finish_time", want.finish_time, got.finish_time);
            check_field("all_idle", 16'(want.all_idle), 16'(got.all_idle));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wr_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [REQ_TYPE_W-1:0] i_req_type;
    logic [JOB_ID_W-1:0]   i_job_id;
    logic [DUR_W-1:0]      i_duration;
    logic [CPU_W-1:0]      i_affinity;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_accepted;
    logic                  o_running_valid;
    logic [JOB_ID_W-1:0]   o_running_job;
    logic                  o_job_finished;
    logic [TICK_W-1:0]     o_finish_time;
    logic                  o_all_idle;

    rr_sched_tracker tracker;
    bit              steady;

    round_robin_quantum_scheduler DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_job_id        (i_job_id),
        .i_duration      (i_duration),
        .i_affinity      (i_affinity),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_accepted      (o_accepted),
        .o_running_valid (o_running_valid),
        .o_running_job   (o_running_job),
        .o_job_finished  (o_job_finished),
        .o_finish_time   (o_finish_time),
        .o_all_idle      (o_all_idle)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (steady || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_req(t_req_type rt, logic [JOB_ID_W-1:0] id,
                            logic [DUR_W-1:0] dur, logic [CPU_W-1:0] aff);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= rt;
        i_job_id   <= id;
        i_duration <= dur;
        i_affinity <= aff;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.apply_request(rt, id, dur, aff);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= idx;
        i_cfg_wr_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tracker.set_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic settle();
        int unsigned waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0 && waited < 5000) begin
            @(negedge i_clk);
            waited++;
        end
        if (tracker.pending_results.size() != 0) begin
            $error("%0d result beats never arrived", tracker.pending_results.size());
            tracker.fail_count++;
            tracker.pending_results.delete();
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send_random_item();
        int unsigned       pick;
        logic [CPU_W-1:0]  aff;
        logic [DUR_W-1:0]  dur;
        pick = $urandom_range(99);
        if (pick < 52) begin
            send_req(REQ_TICK, 8'($urandom), 16'($urandom), 4'($urandom));
        end else begin
            aff = tracker.cpu_id;
            dur = 16'($urandom_range(1, 8));
            if (pick < 62) begin
                dur = 16'($urandom_range(9, 200));
            end else if (pick < 68) begin
                dur = '0;
            end else if (pick < 74) begin
                aff = tracker.cpu_id + 4'($urandom_range(1, 15));
                dur = 16'($urandom);
            end
            send_req(REQ_ARRIVAL, 8'($urandom), dur, aff);
        end
    endtask

    initial begin
        int unsigned stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                tracker.compare_result({o_accepted, o_running_valid, o_running_job,
                                        o_job_finished, o_finish_time, o_all_idle});
            @(negedge i_clk);
            if (steady) begin
                stall_left = 0;
            end else if (stall_left == 0 && $urandom_range(3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #15_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        tracker       = new();
        steady        = 1'b1;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_addr    = CFG_CPU_NUMBER;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_req_type    = REQ_ARRIVAL;
        i_job_id      = '0;
        i_duration    = '0;
        i_affinity    = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset config, back to back beats right after reset
        send_req(REQ_ARRIVAL, 8'h11, 16'd4, 4'd0);
        send_req(REQ_ARRIVAL, 8'h22, 16'd5, 4'd0);
        repeat (12) send_req(REQ_TICK, 8'h00, 16'h0000, 4'h0);
        send_req(REQ_ARRIVAL, 8'h33, 16'd2, 4'd0);
        send_req(REQ_ARRIVAL, 8'h44, 16'd3, 4'd0);
        repeat (6) send_req(REQ_TICK, 8'h00, 16'h0000, 4'h0);
        settle();

        // field extremes, rejects, full queue on arrival and on quantum expiry
        steady = 1'b0;
        write_reg(CFG_CPU_NUMBER, 8'd15);
        write_reg(CFG_TIME_QUANTUM, 8'd2);
        send_req(REQ_ARRIVAL, 8'h00, 16'd1, 4'hF);
        send_req(REQ_ARRIVAL, 8'hFF, 16'd6, 4'hF);
        send_req(REQ_ARRIVAL, 8'h5A, 16'hFFFF, 4'hE);
        send_req(REQ_ARRIVAL, 8'hA5, 16'd0, 4'hF);
        send_req(REQ_TICK, 8'hFF, 16'hFFFF, 4'hF);
        send_req(REQ_TICK, 8'h00, 16'h0000, 4'h0);
        for (int k = 0; k < QUEUE_DEPTH_DEF; k++)
            send_req(REQ_ARRIVAL, 8'(8'h80 + k), 16'(1 + k % 4), 4'hF);
        send_req(REQ_ARRIVAL, 8'h7F, 16'h8000, 4'hF);
        send_req(REQ_TICK, 8'h00, 16'h0000, 4'h0);
        steady = 1'b1;
        while (!tracker.idle())
            send_req(REQ_TICK, 8'h00, 16'h0000, 4'h0);
        settle();

        // zero quantum: 256 ticks per turn
        steady = 1'b0;
        write_reg(CFG_TIME_QUANTUM, 8'd0);
        send_req(REQ_ARRIVAL, 8'h3C, 16'd257, 4'hF);
        send_req(REQ_ARRIVAL, 8'hC3, 16'd2, 4'hF);
        while (!tracker.idle())
            send_req(REQ_TICK, 8'h00, 16'h0000, 4'h0);
        settle();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_CPU_NUMBER, 8'd0);
                    write_reg(CFG_TIME_QUANTUM, 8'd1);
                end
                1: begin
                    write_reg(CFG_CPU_NUMBER, 8'd15);
                    write_reg(CFG_TIME_QUANTUM, 8'd255);
                end
                2: begin
                    write_reg(CFG_CPU_NUMBER, 8'd10);
                    write_reg(CFG_TIME_QUANTUM, 8'd3);
                end
                3: begin
                    write_reg(CFG_CPU_NUMBER, 8'($urandom_range(15)));
                    write_reg(CFG_TIME_QUANTUM, 8'($urandom_range(1, 6)));
                end
                default: begin
                    write_reg(CFG_CPU_NUMBER, 8'd5);
                    write_reg(CFG_TIME_QUANTUM, 8'd2);
                end
            endcase
            steady = (ph == 2);
            repeat (30) send_random_item();
            settle();
        end

        repeat (10) @(negedge i_clk);
        if (tracker.fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
